@@ sv/sfr_pkg.sv @@
// Shared types and constants for the streaming find-and-replace block.
`default_nettype none
package sfr_pkg;

	localparam int unsigned LEN_W   = 4;   // width of a length register
	localparam int unsigned WORD_W  = 64;  // width of a byte-string register
	localparam int unsigned MAX_ALL = 8;   // bytes a string register can carry

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} sfr_reg_t;

	// Live configuration seen by the window logic
	typedef struct packed {
		logic [WORD_W-1:0] pat;
		logic [LEN_W-1:0]  plen;
		logic [WORD_W-1:0] rep;
		logic [LEN_W-1:0]  rlen;
	} sfr_cfg_t;

	// Results caused by one input byte, oldest in the low byte
	typedef struct packed {
		logic [8*MAX_ALL-1:0] bytes;
		logic [LEN_W-1:0]     count;
		logic                 marker;
		logic                 last;
	} sfr_burst_t;

endpackage
`default_nettype wire

@@ sv/sfr_window.sv @@
// Match window: holds pending bytes, compares against the pattern, builds the burst.
`default_nettype none
module sfr_window #(
	parameter int unsigned MAX_PATTERN = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              clear,
	input  wire sfr_pkg::sfr_cfg_t cfg,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output sfr_pkg::sfr_burst_t    burst
);
	import sfr_pkg::*;

	localparam int unsigned FW = $clog2(MAX_PATTERN + 1);

	logic [7:0]       window_q [MAX_PATTERN];
	logic [FW-1:0]    fill_q;
	logic [7:0]       wn [MAX_PATTERN];
	logic [LEN_W-1:0] fill_next;
	logic             full;
	logic             hit;

	// Window with the new byte placed at the fill position, then compare
	always_comb begin
		hit = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			wn[k] = (FW'(k) == fill_q) ? data_byte : window_q[k];
			if ((LEN_W'(k) < cfg.plen) && (wn[k] != cfg.pat[8*k +: 8]))
				hit = 1'b0;
		end
		fill_next = LEN_W'(fill_q) + LEN_W'(1);
		full      = (cfg.plen != '0) && (fill_next == cfg.plen);
	end

	// Assemble the results of this byte
	always_comb begin
		burst        = '0;
		burst.last   = last_byte;
		if (cfg.plen == '0) begin
			burst.bytes[7:0] = data_byte;
			burst.count      = LEN_W'(1);
		end else if (full && hit) begin
			burst.bytes = cfg.rep;
			burst.count = cfg.rlen;
		end else if (last_byte) begin
			// flush everything pending, oldest first
			for (int k = 0; k < MAX_PATTERN; k++)
				burst.bytes[8*k +: 8] = wn[k];
			burst.count = fill_next;
		end else if (full) begin
			burst.bytes[7:0] = wn[0];
			burst.count      = LEN_W'(1);
		end
		if (last_byte && (burst.count == '0)) begin
			burst.bytes  = '0;
			burst.count  = LEN_W'(1);
			burst.marker = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear) begin
			fill_q <= '0;
		end else if (accept && (cfg.plen != '0)) begin
			if (last_byte || (full && hit)) begin
				fill_q <= '0;
			end else if (full) begin
				fill_q <= FW'(cfg.plen - LEN_W'(1));
			end else begin
				fill_q <= FW'(fill_next);
			end
		end
	end

	// Window bytes: payload, no reset
	always_ff @(posedge clk) begin
		if (accept && (cfg.plen != '0) && !last_byte && !(full && hit)) begin
			if (full) begin
				// drop the oldest byte
				for (int k = 0; k < MAX_PATTERN - 1; k++)
					window_q[k] <= wn[k+1];
				window_q[MAX_PATTERN-1] <= wn[MAX_PATTERN-1];
			end else begin
				for (int k = 0; k < MAX_PATTERN; k++)
					window_q[k] <= wn[k];
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/sfr_burst.sv @@
// Result buffer: holds one burst of results and hands them out one per transaction.
`default_nettype none
module sfr_burst #(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire sfr_pkg::sfr_burst_t load_data,
	input  wire logic                result_stall,
	output logic                     free,
	output logic                     result_valid,
	output logic [7:0]               out_byte,
	output logic                     byte_valid,
	output logic                     end_of_string
);
	import sfr_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [8*DEPTH-1:0] buf_q;
	logic [CW-1:0]      cnt_q;
	logic               marker_q;
	logic               last_q;
	logic               pop;

	assign result_valid  = (cnt_q != '0);
	assign pop           = result_valid && !result_stall;
	// take a new burst when empty or when the final entry leaves this cycle
	assign free          = (cnt_q == '0) || ((cnt_q == CW'(1)) && !result_stall);
	assign out_byte      = buf_q[7:0];
	assign byte_valid    = !marker_q;
	assign end_of_string = last_q && (cnt_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			marker_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (load) begin
			cnt_q    <= load_data.count[CW-1:0];
			marker_q <= load_data.marker;
			last_q   <= load_data.last;
		end else if (pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_data.bytes[8*DEPTH-1:0];
		end else if (pop) begin
			buf_q <= buf_q >> 8;
		end
	end

endmodule
`default_nettype wire

@@ sv/stream_find_replace.sv @@
// Top level of the streaming find-and-replace block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  item     | item_valid / item_stall| data_byte, last_byte
//  result   | result_valid/result_stall | out_byte, byte_valid, end_of_string
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An input byte is compared against the pattern in the cycle it is accepted and its
// results (0 to 8) land in the result buffer at the next edge. Results leave one per
// cycle while result_stall is low; a byte that causes one result then lets the next byte
// follow every cycle, while a replacement or flush of n results holds item_stall until its last result leaves.
// Reset clears the window fill, all config registers and the result buffer.
// cfg_ready is always high; write config only while the block is idle.
`default_nettype none
module stream_find_replace #(
	parameter int unsigned MAX_PATTERN     = 8,
	parameter int unsigned MAX_REPLACEMENT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input bytes
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	// rewritten bytes
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             end_of_string,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import sfr_pkg::*;

	// deepest burst: a full-window flush or a full replacement
	localparam int unsigned BURST_DEPTH =
		(MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

	sfr_cfg_t   cfg_q;
	sfr_burst_t burst;
	logic       accept;
	logic       cfg_we;
	logic       plen_we;
	logic       free;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign plen_we    = cfg_we && (sfr_reg_t'(cfg_index) == REG_PATTERN_LENGTH);
	assign item_stall = !free;
	assign accept     = item_valid && !item_stall;

	// Config registers; lengths saturate at the build-time maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (sfr_reg_t'(cfg_index))
				REG_PATTERN_BYTES: begin
					cfg_q.pat <= cfg_data;
				end
				REG_PATTERN_LENGTH: begin
					cfg_q.plen <= (cfg_data[LEN_W-1:0] > LEN_W'(MAX_PATTERN)) ?
						LEN_W'(MAX_PATTERN) : cfg_data[LEN_W-1:0];
				end
				REG_REPLACEMENT_BYTES: begin
					cfg_q.rep <= cfg_data;
				end
				REG_REPLACEMENT_LENGTH: begin
					cfg_q.rlen <= (cfg_data[LEN_W-1:0] > LEN_W'(MAX_REPLACEMENT)) ?
						LEN_W'(MAX_REPLACEMENT) : cfg_data[LEN_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Window and compare; a pattern length write drops pending bytes
	sfr_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.clear     (plen_we),
		.cfg       (cfg_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.burst     (burst)
	);

	// Result buffer drains the burst one transaction at a time
	sfr_burst #(
		.DEPTH(BURST_DEPTH)
	) u_burst (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.load_data     (burst),
		.result_stall  (result_stall),
		.free          (free),
		.result_valid  (result_valid),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string)
	);

endmodule
`default_nettype wire

@@ sv/sfr_checker.sv @@
// Port-level checks for the streaming find-and-replace block, bound to the top level.
`default_nettype none
module sfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic [7:0]  data_byte,
	input wire logic        last_byte,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        byte_valid,
	input wire logic        end_of_string,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [1:0]  cfg_index,
	input wire logic [63:0] cfg_data
);

	// hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(out_byte) && $stable(byte_valid) &&
			$stable(end_of_string))
		else $error("stalled result changed");

	// a byteless result only closes a string
	a_marker_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_valid |-> end_of_string && (out_byte == 8'd0))
		else $error("bare marker not at end of string");

	// never stall input while nothing waits at the output
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty result buffer");

	// an accepted final byte always produces a result at the next edge
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && last_byte |=> result_valid)
		else $error("final byte produced no result");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
`default_nettype wire
